[hdl/apq_pkg.sv]
// Shared types and codes for the array max priority queue.
package apq_pkg;

    localparam int DATA_W = 32;

    typedef enum logic [1:0] {
        MODE_INSERT = 2'd0,
        MODE_DELETE = 2'd1,
        MODE_PEEK   = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_RESP
    } state_t;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        status_t           status;
    } res_t;

endpackage

[hdl/apq_mem.sv]
// Entry store: one write port, one read port, registered read data.
module apq_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic                       aclk,
    input  logic                       wr_en,
    input  logic [AW-1:0]              wr_addr,
    input  logic [apq_pkg::DATA_W-1:0] wr_data,
    input  logic                       rd_en,
    input  logic [AW-1:0]              rd_addr,
    output logic [apq_pkg::DATA_W-1:0] rd_data
);

    logic [apq_pkg::DATA_W-1:0] mem [DEPTH];
    logic [apq_pkg::DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[hdl/apq_ctrl.sv]
// Sequencer: insert, max scan and shift-down over the entry store.
module apq_ctrl #(
    parameter int DEPTH = 16,
    parameter int AW    = 4,
    parameter int CW    = 5
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [1:0]                 in_mode,
    input  logic [apq_pkg::DATA_W-1:0] in_value,
    output logic                       res_valid,
    input  logic                       res_ready,
    output apq_pkg::res_t              res,
    output logic                       wr_en,
    output logic [AW-1:0]              wr_addr,
    output logic [apq_pkg::DATA_W-1:0] wr_data,
    output logic                       rd_en,
    output logic [AW-1:0]              rd_addr,
    input  logic [apq_pkg::DATA_W-1:0] rd_data
);

    apq_pkg::state_t            state_reg, state_next;
    apq_pkg::status_t           st_reg, st_next;
    logic [CW-1:0]              count_reg, count_next;
    logic [CW-1:0]              ptr_reg, ptr_next;
    logic                       rd_vld_reg, rd_vld_next;
    logic [AW-1:0]              rd_idx_reg, rd_idx_next;
    logic [AW-1:0]              best_idx_reg, best_idx_next;
    logic [apq_pkg::DATA_W-1:0] res_val_reg, res_val_next;
    logic                       del_reg, del_next;
    logic                       issue;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= apq_pkg::S_IDLE;
            count_reg  <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            rd_vld_reg <= rd_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        st_reg       <= st_next;
        ptr_reg      <= ptr_next;
        rd_idx_reg   <= rd_idx_next;
        best_idx_reg <= best_idx_next;
        res_val_reg  <= res_val_next;
        del_reg      <= del_next;
    end

    assign issue = (ptr_reg < count_reg);

    always_comb begin
        state_next    = state_reg;
        st_next       = st_reg;
        count_next    = count_reg;
        ptr_next      = ptr_reg;
        rd_vld_next   = 1'b0;
        rd_idx_next   = rd_idx_reg;
        best_idx_next = best_idx_reg;
        res_val_next  = res_val_reg;
        del_next      = del_reg;
        in_ready      = 1'b0;
        res_valid     = 1'b0;
        wr_en         = 1'b0;
        wr_addr       = count_reg[AW-1:0];
        wr_data       = in_value;
        rd_en         = 1'b0;
        rd_addr       = ptr_reg[AW-1:0];

        case (state_reg)
            apq_pkg::S_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    res_val_next = '0;
                    st_next      = apq_pkg::ST_OK;
                    ptr_next     = '0;
                    del_next     = (apq_pkg::mode_t'(in_mode) == apq_pkg::MODE_DELETE);
                    state_next   = apq_pkg::S_RESP;
                    case (apq_pkg::mode_t'(in_mode))
                        apq_pkg::MODE_INSERT: begin
                            if (count_reg < CW'(DEPTH)) begin
                                wr_en      = 1'b1;
                                count_next = count_reg + 1'b1;
                            end else begin
                                st_next = apq_pkg::ST_FULL;
                            end
                        end
                        apq_pkg::MODE_DELETE, apq_pkg::MODE_PEEK: begin
                            if (count_reg == '0) begin
                                st_next = apq_pkg::ST_EMPTY;
                            end else begin
                                state_next = apq_pkg::S_SCAN;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            apq_pkg::S_SCAN: begin
                if (issue) begin
                    rd_en       = 1'b1;
                    rd_vld_next = 1'b1;
                    rd_idx_next = ptr_reg[AW-1:0];
                    ptr_next    = ptr_reg + 1'b1;
                end
                if (rd_vld_reg) begin
                    if (rd_idx_reg == '0 || $signed(rd_data) > $signed(res_val_reg)) begin
                        res_val_next  = rd_data;
                        best_idx_next = rd_idx_reg;
                    end
                end
                if (!issue && !rd_vld_reg) begin
                    if (del_reg) begin
                        ptr_next   = CW'(best_idx_reg) + 1'b1;
                        state_next = apq_pkg::S_SHIFT;
                    end else begin
                        state_next = apq_pkg::S_RESP;
                    end
                end
            end
            apq_pkg::S_SHIFT: begin
                if (issue) begin
                    rd_en       = 1'b1;
                    rd_vld_next = 1'b1;
                    rd_idx_next = ptr_reg[AW-1:0];
                    ptr_next    = ptr_reg + 1'b1;
                end
                if (rd_vld_reg) begin
                    wr_en   = 1'b1;
                    wr_addr = rd_idx_reg - 1'b1;
                    wr_data = rd_data;
                end
                if (!issue && !rd_vld_reg) begin
                    count_next = count_reg - 1'b1;
                    state_next = apq_pkg::S_RESP;
                end
            end
            apq_pkg::S_RESP: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = apq_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = apq_pkg::S_IDLE;
            end
        endcase
    end

    assign res.value  = res_val_reg;
    assign res.status = st_reg;

endmodule

[hdl/array_max_priority_queue.sv]
// Insert, full, empty and unused-mode words respond directly; peek scans every entry for
// the max, and delete then shifts the entries after the max down by one place.
// One word is in work at a time; the store's single read port sets the pace, one entry
// per cycle for both the max scan and the shift-down.
// A new word is taken while a finished result waits in the output register.
// Reset (aresetn low, synchronous) empties the queue; entries need no clearing.
module array_max_priority_queue #(
    parameter int DEPTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value
    input  logic [1:0]  s_tuser,   // [1:0] mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] result_value
    output logic [1:0]  m_tuser    // [1:0] status
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic                       wr_en;
    logic [AW-1:0]              wr_addr;
    logic [apq_pkg::DATA_W-1:0] wr_data;
    logic                       rd_en;
    logic [AW-1:0]              rd_addr;
    logic [apq_pkg::DATA_W-1:0] rd_data;
    logic                       res_valid;
    logic                       res_ready;
    apq_pkg::res_t              res;
    logic                       m_valid_reg, m_valid_next;
    apq_pkg::res_t              m_res_reg;

    apq_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    apq_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_mode   (s_tuser),
        .in_value  (s_tdata),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data)
    );

    assign res_ready = !m_valid_reg || m_tready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (m_tready) begin
            m_valid_next = 1'b0;
        end
        if (res_valid && res_ready) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            m_res_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_res_reg.value;
    assign m_tuser  = m_res_reg.status;

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// Self-checking stream testbench for the array max priority queue with a predicting scoreboard.
module testbench;

    localparam int DEPTH = 16;
    localparam int RANDOM_WORDS = 1500;
    localparam int SETTLE_CYCLES = 2 * DEPTH + 16;
    localparam int HOLD_CYCLES = 400;
    localparam int CYCLE_LIMIT = 1000000;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    class max_queue_scoreboard;
        logic [apq_pkg::DATA_W-1:0] held [DEPTH];
        int held_count;
        apq_pkg::res_t pending_results [$];
        int mismatches;

        function new();
            held_count = 0;
            mismatches = 0;
        endfunction

        function apq_pkg::res_t predict_word(logic [1:0] mode,
                                             logic [apq_pkg::DATA_W-1:0] value);
            apq_pkg::res_t r;
            int top;
            int i;
            r.value = '0;
            r.status = apq_pkg::ST_OK;
            case (mode)
                apq_pkg::MODE_INSERT: begin
                    if (held_count < DEPTH) begin
                        held[held_count] = value;
                        held_count++;
                    end else begin
                        r.status = apq_pkg::ST_FULL;
                    end
                end
                apq_pkg::MODE_DELETE, apq_pkg::MODE_PEEK: begin
                    if (held_count == 0) begin
                        r.status = apq_pkg::ST_EMPTY;
                    end else begin
                        // strict compare keeps the earliest maximum
                        top = 0;
                        for (i = 1; i < held_count; i++)
                            if ($signed(held[i]) > $signed(held[top])) top = i;
                        r.value = held[top];
                        if (mode == apq_pkg::MODE_DELETE) begin
                            for (i = top; i + 1 < held_count; i++) held[i] = held[i + 1];
                            held_count--;
                        end
                    end
                end
                default: ;
            endcase
            return r;
        endfunction

        function void accept_word(logic [1:0] mode, logic [apq_pkg::DATA_W-1:0] value);
            pending_results.push_back(predict_word(mode, value));
        endfunction

        function void check_word(logic [apq_pkg::DATA_W-1:0] value, logic [1:0] status);
            apq_pkg::res_t want;
            if (pending_results.size() == 0) begin
                $error("unexpected result word: result_value %0d status %0d",
                       $signed(value), status);
                mismatches++;
                return;
            end
            want = pending_results.pop_front();
            if (value !== want.value) begin
                $error("result_value: expected %0d, actual %0d",
                       $signed(want.value), $signed(value));
                mismatches++;
            end
            if (status !== want.status) begin
                $error("status: expected %0d, actual %0d", want.status, status);
                mismatches++;
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;   // [31:0] value
    logic [1:0]  s_tuser = '0;   // [1:0] mode
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;        // [31:0] result_value
    logic [1:0]  m_tuser;        // [1:0] status

    max_queue_scoreboard board = new();
    bit steady = 1'b0;
    int hold_off = 0;
    int unsigned cycle_count = 0;

    array_max_priority_queue #(
        .DEPTH(DEPTH)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("array_max_priority_queue regression: fail");
            $finish;
        end
    end

    task automatic send_word(input logic [1:0] mode, input logic [31:0] value);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= mode;
        s_tdata <= value;
        do @(posedge aclk); while (!(s_tvalid && s_tready));
        board.accept_word(mode, value);
    endtask

    // sender pauses until every outstanding result is back
    task automatic wait_results();
        s_tvalid <= 1'b0;
        while (board.pending_results.size() != 0) @(posedge aclk);
    endtask

    function automatic logic [1:0] pick_mode(int insert_pct);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < insert_pct) return apq_pkg::MODE_INSERT;
        if (roll < insert_pct + (100 - insert_pct) * 2 / 3) return apq_pkg::MODE_DELETE;
        if (roll < 99) return apq_pkg::MODE_PEEK;
        return MODE_UNUSED;
    endfunction

    // narrow values give plenty of ties
    function automatic logic [31:0] pick_value(bit narrow);
        case ($urandom_range(0, 9))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2, 3, 4: return int'($urandom_range(0, 7)) - 4;
            default: return narrow ? int'($urandom_range(0, 7)) - 4 : $urandom();
        endcase
    endfunction

    initial begin : result_sink
        int stall;
        do @(posedge aclk); while (!aresetn);
        forever begin
            if (hold_off > 0) begin
                m_tready <= 1'b0;
                repeat (hold_off) @(posedge aclk);
                hold_off = 0;
            end
            stall = steady ? 0 : $urandom_range(0, 6);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
            board.check_word(m_tdata, m_tuser);
        end
    end

    initial begin : stimulus
        int sent;
        int burst;
        int insert_pct;
        bit narrow;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        send_word(apq_pkg::MODE_PEEK, 32'h0000_0000);
        send_word(apq_pkg::MODE_DELETE, 32'hffff_ffff);
        send_word(MODE_UNUSED, 32'h1234_5678);
        send_word(apq_pkg::MODE_INSERT, 32'h7fff_ffff);
        send_word(apq_pkg::MODE_INSERT, 32'h8000_0000);
        send_word(apq_pkg::MODE_INSERT, 32'h0000_0000);
        send_word(apq_pkg::MODE_INSERT, 32'hffff_ffff);
        send_word(apq_pkg::MODE_INSERT, 32'h7fff_ffff);
        send_word(MODE_UNUSED, 32'hffff_ffff);
        send_word(apq_pkg::MODE_PEEK, 32'hffff_ffff);
        send_word(apq_pkg::MODE_DELETE, 32'h0000_0000);
        send_word(apq_pkg::MODE_DELETE, 32'h0000_0000);
        send_word(apq_pkg::MODE_DELETE, 32'h0000_0000);
        send_word(apq_pkg::MODE_DELETE, 32'h0000_0000);
        send_word(apq_pkg::MODE_PEEK, 32'h0000_0000);
        send_word(apq_pkg::MODE_DELETE, 32'h0000_0000);
        send_word(apq_pkg::MODE_PEEK, 32'h0000_0000);
        wait_results();

        // long output stall while words keep coming
        hold_off = HOLD_CYCLES;
        steady = 1'b1;
        repeat (24) send_word(pick_mode(60), pick_value(1'b0));
        steady = 1'b0;
        wait_results();

        sent = 0;
        while (sent < RANDOM_WORDS) begin
            case ($urandom_range(0, 2))
                0: insert_pct = 85;
                1: insert_pct = 20;
                default: insert_pct = 50;
            endcase
            narrow = $urandom_range(0, 1);
            steady = ($urandom_range(0, 5) == 0);
            burst = $urandom_range(10, 60);
            repeat (burst) send_word(pick_mode(insert_pct), pick_value(narrow));
            sent += burst;
            if ($urandom_range(0, 7) == 0) wait_results();
        end
        steady = 1'b0;

        wait_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (board.mismatches == 0 && board.pending_results.size() == 0) begin
            $display("array_max_priority_queue regression: pass");
        end else begin
            $display("array_max_priority_queue regression: fail");
        end
        $finish;
    end
endmodule

[array_max_priority_queue.f]
hdl/apq_pkg.sv
hdl/apq_mem.sv
hdl/apq_ctrl.sv
hdl/array_max_priority_queue.sv
tb/testbench.sv
